// ===== hdl/tea_pkg.sv =====
// Shared types and constants for the TEA block cipher core.
// No dependencies; imported by every other file in hdl/.
`default_nettype none

package tea_pkg;

	// Key schedule constant added once per round
	localparam logic [31:0] TEA_DELTA = 32'h9e3779b9;

	// Width of the configuration register index
	localparam int CFG_INDEX_W = 3;

	typedef logic [31:0] word_t;

	// Key words and direction, as held by the configuration registers
	typedef struct packed {
		word_t k0;
		word_t k1;
		word_t k2;
		word_t k3;
		logic  decrypt;
	} key_t;

endpackage : tea_pkg

`default_nettype wire

// ===== hdl/tea_block_cipher_core.sv =====
// Top level of the TEA block cipher core: configuration registers and round pipeline.
// Depends on tea_pkg, tea_cfg_regs and tea_half_round.
`default_nettype none

// TEA block cipher, 64-bit block, 128-bit key, ROUND_COUNT Feistel rounds.
// A request (first_word, second_word) is taken at any rising edge where start
// is high; busy is always low, so a new block may enter every cycle. Each
// round is split into two registered half-rounds, 2*ROUND_COUNT stages in all;
// done and the result are the last stage's registers, so they appear together.
// Throughput is one block per cycle: every stage is a plain register that
// advances each cycle, and nothing feeds back from one block to the next.
// done lasts one cycle and the
// receiver cannot stall the pipeline, so capture results when done is seen.
// Key words (indices 0..3) and decrypt_mode (index 4) are written through
// cfg_write/cfg_index/cfg_data; write them only while no block is in flight.
// The per-round sums are constants built into each stage, so nothing carries
// from one block to the next.
module tea_block_cipher_core #(
	parameter int ROUND_COUNT = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [tea_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire tea_pkg::word_t                  cfg_data,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire tea_pkg::word_t                  first_word,
	input  wire tea_pkg::word_t                  second_word,
	output logic                                 done,
	output tea_pkg::word_t                       first_result,
	output tea_pkg::word_t                       second_result
);
	import tea_pkg::*;

	localparam int STAGES = 2 * ROUND_COUNT;

	key_t  key;
	logic  valid_st [0:STAGES];
	word_t a_st     [0:STAGES];
	word_t b_st     [0:STAGES];

	// Hold the key and direction for the whole pipeline
	tea_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.key       (key)
	);

	// The pipeline never stalls, so take a request every cycle
	assign busy = 1'b0;

	assign valid_st[0] = start;
	assign a_st[0]     = first_word;
	assign b_st[0]     = second_word;

	// Two stages per round; round r uses (r+1)*delta when encrypting and
	// (ROUND_COUNT-r)*delta when decrypting, folded at elaboration
	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		localparam logic [63:0] ENC_PROD = 64'(i / 2 + 1) * 64'(TEA_DELTA);
		localparam logic [63:0] DEC_PROD = 64'(ROUND_COUNT - i / 2) * 64'(TEA_DELTA);

		tea_half_round #(
			.SUM_ENC    (ENC_PROD[31:0]),
			.SUM_DEC    (DEC_PROD[31:0]),
			.FIRST_HALF ((i % 2) == 0)
		) u_half (
			.clk      (clk),
			.arst_n   (arst_n),
			.key      (key),
			.valid_in (valid_st[i]),
			.a_in     (a_st[i]),
			.b_in     (b_st[i]),
			.valid_s1 (valid_st[i+1]),
			.a_s1     (a_st[i+1]),
			.b_s1     (b_st[i+1])
		);
	end

	// Present the last stage's registers directly
	assign done          = valid_st[STAGES];
	assign first_result  = a_st[STAGES];
	assign second_result = b_st[STAGES];

endmodule : tea_block_cipher_core

`default_nettype wire

// ===== hdl/tea_cfg_regs.sv =====
// Configuration registers of the TEA core: four key words and the direction bit.
// Depends on tea_pkg.
`default_nettype none

module tea_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [tea_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire tea_pkg::word_t                  cfg_data,
	output tea_pkg::key_t                        key
);
	import tea_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD0    = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD1    = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD2    = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD3    = CFG_INDEX_W'(3);
	localparam logic [CFG_INDEX_W-1:0] REG_DECRYPT_MODE = CFG_INDEX_W'(4);

	key_t key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_KEY_WORD0:    key_q.k0      <= cfg_data;
				REG_KEY_WORD1:    key_q.k1      <= cfg_data;
				REG_KEY_WORD2:    key_q.k2      <= cfg_data;
				REG_KEY_WORD3:    key_q.k3      <= cfg_data;
				REG_DECRYPT_MODE: key_q.decrypt <= cfg_data[0];
				default: ; // drop writes to unused indices
			endcase
		end
	end

	assign key = key_q;

endmodule : tea_cfg_regs

`default_nettype wire

// ===== hdl/tea_half_round.sv =====
// One registered half of a TEA Feistel round: updates one word of the block.
// Depends on tea_pkg.
`default_nettype none

module tea_half_round #(
	parameter logic [31:0] SUM_ENC    = 32'h9e3779b9,
	parameter logic [31:0] SUM_DEC    = 32'h9e3779b9,
	parameter bit          FIRST_HALF = 1'b1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tea_pkg::key_t  key,
	input  wire logic           valid_in,
	input  wire tea_pkg::word_t a_in,
	input  wire tea_pkg::word_t b_in,
	output logic                valid_s1,
	output tea_pkg::word_t      a_s1,
	output tea_pkg::word_t      b_s1
);
	import tea_pkg::*;

	function automatic word_t mix(word_t x, word_t sum, word_t ka, word_t kb);
		return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
	endfunction

	logic  update_a;
	word_t sum;
	word_t src;
	word_t dst;
	word_t mixed;
	word_t next_word;

	// Encryption updates a then b; decryption undoes b first, then a
	assign update_a  = key.decrypt ? !FIRST_HALF : FIRST_HALF;
	assign sum       = key.decrypt ? SUM_DEC : SUM_ENC;
	assign src       = update_a ? b_in : a_in;
	assign dst       = update_a ? a_in : b_in;
	assign mixed     = update_a ? mix(src, sum, key.k0, key.k1)
	                            : mix(src, sum, key.k2, key.k3);
	assign next_word = key.decrypt ? (dst - mixed) : (dst + mixed);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= update_a ? next_word : a_in;
		b_s1 <= update_a ? b_in : next_word;
	end

endmodule : tea_half_round

`default_nettype wire
